// ===== hdl/itoa_pkg.sv =====
// ----------------------------------------------------------------------------
// itoa_pkg: shared types and constants for the integer to ASCII formatter
// Holds format codes, ASCII constants, the digit-to-character mapping and
// the command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package itoa_pkg;

  // Format selector codes
  localparam logic [1:0] TYPE_DEC_SIGNED   = 2'd0;
  localparam logic [1:0] TYPE_DEC_UNSIGNED = 2'd1;
  localparam logic [1:0] TYPE_HEX_LOWER    = 2'd2;
  localparam logic [1:0] TYPE_HEX_UPPER    = 2'd3;

  // ASCII codes
  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_MINUS   = 8'h2D;
  localparam logic [7:0] ASCII_LOWER_A = 8'h61;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;

  // Reciprocal of ten for a 32-bit dividend: q = (x * RECIP_TEN) >> RECIP_SHIFT
  localparam logic [31:0] RECIP_TEN   = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam int STORE_DEPTH = 16;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // capture a new word and clear the digit store
    logic mul;         // multiply the quotient by the reciprocal of ten
    logic div;         // finish the decimal step and store one digit
    logic hex;         // store one hex digit and shift the quotient
    logic emit_sign;   // load a minus sign into the output register
    logic emit_digit;  // load the next stored digit into the output register
  } itoa_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic quo_zero;    // decimal quotient after this step is zero
    logic hex_done;    // hex quotient after this step is zero
    logic neg;         // a minus sign precedes the digits
    logic last_digit;  // one stored digit is left to send
    logic out_free;    // the output register can take a new word
  } itoa_status_t;

  // Map a digit value to its ASCII character
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] ext;
    ext = {4'b0000, d};
    if (d < 4'd10) begin
      digit_char = ASCII_ZERO + ext;
    end else if (upper) begin
      digit_char = ASCII_UPPER_A + ext - 8'd10;
    end else begin
      digit_char = ASCII_LOWER_A + ext - 8'd10;
    end
  endfunction

endpackage

// ===== hdl/integer_to_ascii_formatter_unit.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_unit: integer to ASCII text formatter
// Converts one integer per input word into its decimal or hex text.
// ----------------------------------------------------------------------------
// Usage:
//   Input word: in_tuser selects the format (signed decimal, unsigned
//   decimal, hex lower, hex upper), in_tdata carries the 64-bit value.
//   Decimal formats use only bits 31..0.
//   Output words: one ASCII character each, most significant digit first,
//   with a leading minus for negative signed values. out_tlast marks the
//   final character, whose out_tdata also carries the character count.
//   Flow: a word is taken when the unit is idle. Each decimal digit takes a
//   reciprocal multiply step, then a reduce step; each hex digit takes a
//   shift-and-store step. Then one character leaves per cycle through the
//   output register while the receiver is ready. The next word is taken
//   once the last character sits in the output register. A stalled
//   receiver holds the output register and pauses emission; no character
//   is dropped. Reset empties the output register and returns the
//   controller to idle.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [63:0] value
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] char_code, [12:8] char_count, [15:13] zero
  output logic        out_tlast
);

  itoa_pkg::itoa_cmd_t    cmd;
  itoa_pkg::itoa_status_t status;
  logic [7:0]             out_char;
  logic [4:0]             out_count;

  itoa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_type  (in_tuser),
    .status   (status),
    .cmd      (cmd)
  );

  itoa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_type   (in_tuser),
    .in_value  (in_tdata),
    .status    (status),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (out_char),
    .out_last  (out_tlast),
    .out_count (out_count)
  );

  // Pack the output word
  assign out_tdata = {3'b000, out_count, out_char};

endmodule

// ===== hdl/itoa_dp.sv =====
// ----------------------------------------------------------------------------
// itoa_dp: formatter datapath
// Quotient register, reciprocal multiplier, digit store and the output
// register. Acts only on commands from the controller.
// ----------------------------------------------------------------------------
module itoa_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  itoa_pkg::itoa_cmd_t    cmd,
  input  logic [1:0]             in_type,
  input  logic [63:0]            in_value,
  output itoa_pkg::itoa_status_t status,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [7:0]             out_char,
  output logic                   out_last,
  output logic [4:0]             out_count
);

  logic [63:0] q_r;
  logic [28:0] quo_r;
  logic [7:0]  store_r [itoa_pkg::STORE_DEPTH];
  logic [4:0]  count_r;
  logic [4:0]  ptr_r;
  logic        neg_r;
  logic        upper_r;
  logic        out_valid_r;
  logic [7:0]  out_char_r;
  logic        out_last_r;
  logic [4:0]  out_count_r;

  logic [31:0] low;
  logic [31:0] low_neg;
  logic [63:0] prod_nxt;
  logic [31:0] tenq;
  logic [31:0] rem;
  logic [4:0]  ptr_dec;
  logic [7:0]  dig_char;

  // Decimal remainder: x - 10 * floor(x / 10)
  assign low      = in_value[31:0];
  assign low_neg  = 32'd0 - low;
  assign prod_nxt = {32'd0, q_r[31:0]} * {32'd0, itoa_pkg::RECIP_TEN};
  assign tenq     = {quo_r, 3'b000} + {2'b00, quo_r, 1'b0};
  assign rem      = q_r[31:0] - tenq;
  assign ptr_dec  = ptr_r - 5'd1;
  assign dig_char = itoa_pkg::digit_char(cmd.hex ? q_r[3:0] : rem[3:0], upper_r);

  // Quotient, multiplier product and letter case
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      upper_r <= (in_type == itoa_pkg::TYPE_HEX_UPPER);
      if (in_type == itoa_pkg::TYPE_DEC_SIGNED) begin
        q_r <= {32'd0, low[31] ? low_neg : low};
      end else if (in_type == itoa_pkg::TYPE_DEC_UNSIGNED) begin
        q_r <= {32'd0, low};
      end else begin
        q_r <= in_value;
      end
    end else if (cmd.div) begin
      q_r <= {35'd0, quo_r};
    end else if (cmd.hex) begin
      q_r <= {4'b0000, q_r[63:4]};
    end
    if (cmd.mul) begin
      quo_r <= prod_nxt[63:itoa_pkg::RECIP_SHIFT];
    end
  end

  // Digit store, written least significant digit first
  always_ff @(posedge clk) begin
    if (cmd.div || cmd.hex) begin
      store_r[count_r[3:0]] <= dig_char;
    end
  end

  // Counts and sign flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ptr_r   <= '0;
      neg_r   <= 1'b0;
    end else if (cmd.load) begin
      count_r <= '0;
      ptr_r   <= '0;
      neg_r   <= (in_type == itoa_pkg::TYPE_DEC_SIGNED) && low[31];
    end else if (cmd.div || cmd.hex) begin
      count_r <= count_r + 5'd1;
      ptr_r   <= ptr_r + 5'd1;
    end else if (cmd.emit_digit) begin
      ptr_r   <= ptr_dec;
    end
  end

  // Output register: load on emit, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_sign || cmd.emit_digit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_sign) begin
      out_char_r  <= itoa_pkg::ASCII_MINUS;
      out_last_r  <= 1'b0;
      out_count_r <= '0;
    end else if (cmd.emit_digit) begin
      out_char_r  <= store_r[ptr_dec[3:0]];
      out_last_r  <= (ptr_r == 5'd1);
      out_count_r <= (ptr_r == 5'd1) ? count_r + {4'b0000, neg_r} : 5'd0;
    end
  end

  assign status.quo_zero   = (quo_r == '0);
  assign status.hex_done   = (q_r[63:4] == '0);
  assign status.neg        = neg_r;
  assign status.last_digit = (ptr_r == 5'd1);
  assign status.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;
  assign out_count = out_count_r;

  // Store never overflows
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= 5'd16) else $error("digit count beyond store depth");

  // A digit is sent only while one is stored
  a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_digit |-> ptr_r != 5'd0) else $error("emit with empty store");

  // The final character always carries a nonzero count
  a_last_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_count_r != 5'd0) else $error("zero count on last");

endmodule

// ===== hdl/itoa_ctrl.sv =====
// ----------------------------------------------------------------------------
// itoa_ctrl: formatter controller
// Sequences load, digit extraction and character emission for one word.
// ----------------------------------------------------------------------------
module itoa_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_type,
  input  itoa_pkg::itoa_status_t status,
  output itoa_pkg::itoa_cmd_t    cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_DIV    = 3'd2;
  localparam logic [2:0] ST_HEX    = 3'd3;
  localparam logic [2:0] ST_SIGN   = 3'd4;
  localparam logic [2:0] ST_DIGITS = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       is_dec;

  assign is_dec   = (in_type == itoa_pkg::TYPE_DEC_SIGNED) ||
                    (in_type == itoa_pkg::TYPE_DEC_UNSIGNED);
  assign in_ready = (state_r == ST_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = is_dec ? ST_MUL : ST_HEX;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (status.quo_zero) begin
          state_nxt = status.neg ? ST_SIGN : ST_DIGITS;
        end else begin
          state_nxt = ST_MUL;
        end
      end
      ST_HEX: begin
        cmd.hex = 1'b1;
        if (status.hex_done) begin
          state_nxt = ST_DIGITS;
        end
      end
      ST_SIGN: begin
        if (status.out_free) begin
          cmd.emit_sign = 1'b1;
          state_nxt     = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (status.out_free) begin
          cmd.emit_digit = 1'b1;
          if (status.last_digit) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Only a load is issued while waiting for a word
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !(cmd.mul || cmd.div || cmd.hex || cmd.emit_sign ||
                             cmd.emit_digit)) else $error("command while idle");

  // A multiply is always followed by the reduction step
  a_mul_then_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul |=> cmd.div) else $error("multiply not followed by reduce");

  // Nothing is emitted unless the output register has room
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit_sign || cmd.emit_digit) |-> status.out_free) else $error("emit into full output");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the integer to ASCII formatter
// Sends signed, unsigned and hex requests over the input stream. A local
// formatter fills in the expected text the table omits; every output word
// is checked against it. Both stream sides idle at random, with a calm
// stretch and a long receiver stall that backs the unit up into its input.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
    logic [4:0] count;
  } char_word_t;

  // An empty text means the local formatter supplies the expected characters
  typedef struct {
    logic [1:0]  fmt;
    logic [63:0] value;
    string       text;
  } number_row_t;

  typedef enum logic [1:0] {RX_RANDOM, RX_ALWAYS, RX_HOLD} rx_mode_t;

  localparam int IDLE_PCT     = 33;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_WORDS = 480;
  localparam int CALM_WORDS   = 120;
  localparam int DRAIN_CYCLES = 40;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tlast;

  char_word_t  expected_chars[$];
  int          error_count = 0;
  logic        tx_calm     = 1'b0;
  rx_mode_t    rx_mode     = RX_RANDOM;
  int          hold_count  = 0;

  number_row_t directed_rows [22] = '{
    '{itoa_pkg::TYPE_DEC_SIGNED,   64'h0000_0000_0000_0000, "0"},
    '{itoa_pkg::TYPE_DEC_SIGNED,   64'h0000_0000_7FFF_FFFF, "2147483647"},
    '{itoa_pkg::TYPE_DEC_SIGNED,   64'h0000_0000_8000_0000, "-2147483648"},
    '{itoa_pkg::TYPE_DEC_SIGNED,   64'h0000_0000_8000_0001, "-2147483647"},
    '{itoa_pkg::TYPE_DEC_SIGNED,   64'hFFFF_FFFF_FFFF_FFFF, "-1"},
    '{itoa_pkg::TYPE_DEC_SIGNED,   64'hDEAD_BEEF_0000_0009, "9"},
    '{itoa_pkg::TYPE_DEC_SIGNED,   64'h0000_0000_3B9A_CA00, "1000000000"},
    '{itoa_pkg::TYPE_DEC_SIGNED,   64'h0123_4567_89AB_CDEF, ""},
    '{itoa_pkg::TYPE_DEC_UNSIGNED, 64'h0000_0000_0000_0000, "0"},
    '{itoa_pkg::TYPE_DEC_UNSIGNED, 64'h0000_0000_FFFF_FFFF, "4294967295"},
    '{itoa_pkg::TYPE_DEC_UNSIGNED, 64'hFFFF_FFFF_0000_0000, "0"},
    '{itoa_pkg::TYPE_DEC_UNSIGNED, 64'h0000_0000_8000_0000, "2147483648"},
    '{itoa_pkg::TYPE_DEC_UNSIGNED, 64'h5555_AAAA_1234_5678, ""},
    '{itoa_pkg::TYPE_HEX_LOWER,    64'h0000_0000_0000_0000, "0"},
    '{itoa_pkg::TYPE_HEX_LOWER,    64'hFFFF_FFFF_FFFF_FFFF, "ffffffffffffffff"},
    '{itoa_pkg::TYPE_HEX_LOWER,    64'h8000_0000_0000_0000, "8000000000000000"},
    '{itoa_pkg::TYPE_HEX_LOWER,    64'h0123_4567_89AB_CDEF, "123456789abcdef"},
    '{itoa_pkg::TYPE_HEX_LOWER,    64'hA5A5_5A5A_C3C3_3C3C, ""},
    '{itoa_pkg::TYPE_HEX_UPPER,    64'h0000_0000_0000_0000, "0"},
    '{itoa_pkg::TYPE_HEX_UPPER,    64'hFFFF_FFFF_FFFF_FFFF, "FFFFFFFFFFFFFFFF"},
    '{itoa_pkg::TYPE_HEX_UPPER,    64'hFEDC_BA98_7654_3210, "FEDCBA9876543210"},
    '{itoa_pkg::TYPE_HEX_UPPER,    64'h0000_0000_0000_000A, "A"}
  };

  integer_to_ascii_formatter_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Build the text of one number, most significant character first
  function automatic string format_number(input logic [1:0] fmt, input logic [63:0] value);
    logic [63:0] mag;
    logic [63:0] base;
    logic [31:0] low;
    logic        neg;
    string       digits;
    string       text;
    low    = value[31:0];
    neg    = 1'b0;
    text   = "";
    digits = (fmt == itoa_pkg::TYPE_HEX_UPPER) ? "0123456789ABCDEF" : "0123456789abcdef";
    case (fmt)
      itoa_pkg::TYPE_DEC_SIGNED: begin
        neg  = low[31];
        mag  = {32'd0, neg ? (~low + 32'd1) : low};
        base = 64'd10;
      end
      itoa_pkg::TYPE_DEC_UNSIGNED: begin
        mag  = {32'd0, low};
        base = 64'd10;
      end
      default: begin
        mag  = value;
        base = 64'd16;
      end
    endcase
    do begin
      text = $sformatf("%c%s", digits.getc(int'(mag % base)), text);
      mag  = mag / base;
    end while (mag != 64'd0);
    if (neg) begin
      text = {"-", text};
    end
    return text;
  endfunction

  // Turn a text into expected output words; the final one carries the count
  function automatic void queue_text(input string text);
    char_word_t w;
    int         n;
    n = text.len();
    for (int i = 0; i < n; i++) begin
      w.code  = text.getc(i);
      w.last  = (i == n - 1);
      w.count = (i == n - 1) ? 5'(n) : 5'd0;
      expected_chars.push_back(w);
    end
  endfunction

  // Mix full-width values, short values and decimal boundaries
  function automatic logic [63:0] random_value();
    logic [63:0] raw;
    logic [31:0] p;
    int          k;
    raw = {$urandom, $urandom};
    case ($urandom_range(4))
      0: return raw;
      1: return raw >> $urandom_range(63);
      2: return 64'($urandom_range(20));
      3: begin
        p = 32'd1;
        k = $urandom_range(9);
        repeat (k) p = p * 32'd10;
        return {raw[63:32], p - 32'($urandom_range(1))};
      end
      default: begin
        p = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        return {raw[63:32], p ^ 32'($urandom_range(3))};
      end
    endcase
  endfunction

  task automatic report_mismatch(input string field, input longint unsigned got,
                                 input longint unsigned want);
    $display("MISMATCH %s: got %0h expected %0h at %0t", field, got, want, $time);
    error_count++;
  endtask

  // Offer one word, wait for it to be taken and queue its text; enter and leave at negedge
  task automatic send_number(input logic [1:0] fmt, input logic [63:0] value,
                             input string text);
    if (!tx_calm) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        in_tdata  <= {$urandom, $urandom};
        in_tuser  <= 2'($urandom);
        @(negedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= fmt;
    do @(posedge clk); while (!in_tready);
    queue_text(text == "" ? format_number(fmt, value) : text);
    @(negedge clk);
  endtask

  // Receiver: random backpressure, a calm stretch, and one long hold-off
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      case (rx_mode)
        RX_HOLD: begin
          out_tready <= 1'b0;
          hold_count++;
          if (hold_count >= HOLD_CYCLES) begin
            hold_count = 0;
            rx_mode    = RX_RANDOM;
          end
        end
        RX_ALWAYS: out_tready <= 1'b1;
        default:   out_tready <= ($urandom_range(99) >= IDLE_PCT);
      endcase
    end
  end

  // Check each accepted output word against the oldest expected character
  always @(posedge clk) begin
    char_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_chars.size() == 0) begin
        report_mismatch("unexpected word", out_tdata, 0);
      end else begin
        want = expected_chars.pop_front();
        if (out_tdata[7:0] != want.code) begin
          report_mismatch("char_code", out_tdata[7:0], want.code);
        end
        if (out_tlast != want.last) begin
          report_mismatch("last", out_tlast, want.last);
        end
        if (out_tdata[12:8] != want.count) begin
          report_mismatch("char_count", out_tdata[12:8], want.count);
        end
        if (out_tdata[15:13] != 3'b000) begin
          report_mismatch("pad bits", out_tdata[15:13], 0);
        end
      end
    end
  end

  // Stimulus: directed table, calm random run, pressure, then random idling
  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 64'd0;
    in_tuser  = itoa_pkg::TYPE_DEC_SIGNED;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      send_number(directed_rows[i].fmt, directed_rows[i].value, directed_rows[i].text);
    end

    tx_calm = 1'b1;
    rx_mode = RX_ALWAYS;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == CALM_WORDS) begin
        tx_calm = 1'b0;
        rx_mode = RX_HOLD;
      end
      send_number(2'($urandom), random_value(), "");
    end
    in_tvalid <= 1'b0;

    // Drain outstanding characters, then allow for stray output
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/itoa_pkg.sv
hdl/itoa_dp.sv
hdl/itoa_ctrl.sv
hdl/integer_to_ascii_formatter_unit.sv
tb/testbench.sv
